// File: rtl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the signature seen-set duplicate filter.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Table geometry (power of two, so the home slot is a plain mask)
  localparam int TABLE_ENTRIES = 1024;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int COUNT_W       = 11;
  localparam int SIG_WORDS     = 8;
  localparam int WORD_W        = 64;
  localparam int SIG_W         = SIG_WORDS * WORD_W;
  localparam int HASH_W        = 32;
  // Stored row: valid flag on top of the signature
  localparam int ROW_W         = SIG_W + 1;
  localparam int STATUS_W      = 2;

  // Result codes
  localparam logic [STATUS_W-1:0] STAT_NEW  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                clear_wr;
    logic                load;
    logic                rd_en;
    logic                advance;
    logic                commit;
    logic                wr_new;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic hit_empty;
    logic hit_match;
    logic wrap;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/sss_in_if.sv
// ----------------------------------------------------------------------------
// sss_in_if
// Input channel: one 512-bit signature as eight 64-bit words per transfer.
// ----------------------------------------------------------------------------
interface sss_in_if;
  logic                        valid;
  logic                        ready;
  logic [sss_pkg::WORD_W-1:0]  sig_word_0;
  logic [sss_pkg::WORD_W-1:0]  sig_word_1;
  logic [sss_pkg::WORD_W-1:0]  sig_word_2;
  logic [sss_pkg::WORD_W-1:0]  sig_word_3;
  logic [sss_pkg::WORD_W-1:0]  sig_word_4;
  logic [sss_pkg::WORD_W-1:0]  sig_word_5;
  logic [sss_pkg::WORD_W-1:0]  sig_word_6;
  logic [sss_pkg::WORD_W-1:0]  sig_word_7;

  modport source (
    output valid, sig_word_0, sig_word_1, sig_word_2, sig_word_3,
           sig_word_4, sig_word_5, sig_word_6, sig_word_7,
    input  ready
  );
  modport sink (
    input  valid, sig_word_0, sig_word_1, sig_word_2, sig_word_3,
           sig_word_4, sig_word_5, sig_word_6, sig_word_7,
    output ready
  );
endinterface

// File: rtl/sss_out_if.sv
// ----------------------------------------------------------------------------
// sss_out_if
// Result channel: status, slot and entry count per transfer.
// ----------------------------------------------------------------------------
interface sss_out_if;
  logic                          valid;
  logic                          ready;
  logic [sss_pkg::STATUS_W-1:0]  status;
  logic [sss_pkg::SLOT_W-1:0]    slot;
  logic [sss_pkg::COUNT_W-1:0]   entry_count;

  modport source (
    output valid, status, slot, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot, entry_count,
    output ready
  );
endinterface

// File: rtl/signature_seen_set.sv
// ----------------------------------------------------------------------------
// signature_seen_set
// Duplicate filter for 512-bit signatures in a linearly probed hash table.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------
//  in_chan   | sink      | sig_word_0 .. sig_word_7 (64 bits each)
//  out_chan  | source    | status (2), slot (10), entry_count (11)
//
//  Steps: an accept state, then per probe a table read and a compare;
//  the single table read port sets this pace.
//  Reset: a clearing pass writes every row empty; no input
//  transfer is taken during it.
//  Stalls: one result waits in the output register while the next item is
//  accepted and probed; the compare step holds until that register is free.
// ----------------------------------------------------------------------------
module signature_seen_set (
  input  logic       clk,
  input  logic       rst_n,
  sss_in_if.sink     in_chan,
  sss_out_if.source  out_chan
);

  sss_pkg::cmd_t             cmd;
  sss_pkg::sts_t             sts;
  logic [sss_pkg::SIG_W-1:0] sig_in;
  logic                      in_ready;

  // Pack the words, word 0 lowest
  assign sig_in = {in_chan.sig_word_7, in_chan.sig_word_6, in_chan.sig_word_5,
                   in_chan.sig_word_4, in_chan.sig_word_3, in_chan.sig_word_2,
                   in_chan.sig_word_1, in_chan.sig_word_0};

  assign in_chan.ready = in_ready;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sss_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .sig_in          (sig_in),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_slot        (out_chan.slot),
    .out_entry_count (out_chan.entry_count)
  );

endmodule

// File: rtl/sss_ctrl.sv
// ----------------------------------------------------------------------------
// sss_ctrl
// Controller: clearing pass after reset, then accept, read, check per probe.
// ----------------------------------------------------------------------------
module sss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sss_pkg::sts_t sts,
  output sss_pkg::cmd_t cmd
);

  sss_pkg::state_t state_r;
  sss_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sss_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      sss_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) begin
          state_nxt = sss_pkg::ST_IDLE;
        end
      end
      sss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sss_pkg::ST_READ;
        end
      end
      sss_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = sss_pkg::ST_CHECK;
      end
      sss_pkg::ST_CHECK: begin
        // On a result, hold here while the output register is still occupied
        if (sts.hit_empty) begin
          cmd.res_status = sss_pkg::STAT_NEW;
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            cmd.wr_new = 1'b1;
            state_nxt  = sss_pkg::ST_IDLE;
          end
        end else if (sts.hit_match) begin
          cmd.res_status = sss_pkg::STAT_DUP;
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = sss_pkg::ST_IDLE;
          end
        end else if (sts.wrap) begin
          cmd.res_status = sss_pkg::STAT_FULL;
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = sss_pkg::ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = sss_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = sss_pkg::ST_CLEAR;
      end
    endcase
  end

  // Assertions
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == sss_pkg::ST_READ)
    else $error("load did not start a probe");
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result committed into an occupied output register");
  a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_new |-> sts.hit_empty && cmd.commit)
    else $error("insert without an empty slot");

endmodule

// File: rtl/sss_datapath.sv
// ----------------------------------------------------------------------------
// sss_datapath
// Datapath: signature table memory, probe slot, entry count, output register.
// ----------------------------------------------------------------------------
module sss_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sss_pkg::SIG_W-1:0]    sig_in,
  input  sss_pkg::cmd_t                cmd,
  output sss_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sss_pkg::STATUS_W-1:0] out_status,
  output logic [sss_pkg::SLOT_W-1:0]   out_slot,
  output logic [sss_pkg::COUNT_W-1:0]  out_entry_count
);

  // Table: valid flag plus signature per row
  logic [sss_pkg::ROW_W-1:0]    mem [sss_pkg::TABLE_ENTRIES];
  logic [sss_pkg::ROW_W-1:0]    rd_row_r;

  logic [sss_pkg::SIG_W-1:0]    sig_r;
  logic [sss_pkg::SLOT_W-1:0]   slot_r;
  logic [sss_pkg::SLOT_W-1:0]   start_r;
  logic [sss_pkg::SLOT_W-1:0]   clr_r;
  logic [sss_pkg::COUNT_W-1:0]  count_r;
  logic [sss_pkg::COUNT_W-1:0]  count_nxt;

  logic                         out_valid_r;
  logic [sss_pkg::STATUS_W-1:0] out_status_r;
  logic [sss_pkg::SLOT_W-1:0]   out_slot_r;
  logic [sss_pkg::COUNT_W-1:0]  out_count_r;

  logic [sss_pkg::SLOT_W-1:0]   hash;
  logic [sss_pkg::SLOT_W-1:0]   next_slot;
  logic                         wr_en;
  logic [sss_pkg::SLOT_W-1:0]   wr_addr;
  logic [sss_pkg::ROW_W-1:0]    wr_row;

  // Fold word 0 into 32 bits and keep only the slot bits as the home slot
  assign hash = sig_in[sss_pkg::SLOT_W-1:0]
              ^ sig_in[sss_pkg::HASH_W +: sss_pkg::SLOT_W];

  // Linear probe step, wrapping through the slot width
  assign next_slot = slot_r + sss_pkg::SLOT_W'(1);

  // Status back to the controller
  assign sts.clear_done = (clr_r == {sss_pkg::SLOT_W{1'b1}});
  assign sts.hit_empty  = !rd_row_r[sss_pkg::ROW_W-1];
  assign sts.hit_match  = (rd_row_r[sss_pkg::SIG_W-1:0] == sig_r);
  assign sts.wrap       = (next_slot == start_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Table write: clearing pass or insertion
  assign wr_en   = cmd.clear_wr || cmd.wr_new;
  assign wr_addr = cmd.clear_wr ? clr_r : slot_r;
  assign wr_row  = cmd.clear_wr ? '0 : {1'b1, sig_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd_en) begin
      rd_row_r <= mem[slot_r];
    end
  end

  // Capture the signature and its home slot; advance the probe
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sig_r   <= sig_in;
      slot_r  <= hash;
      start_r <= hash;
    end else if (cmd.advance) begin
      slot_r  <= next_slot;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_r <= clr_r + sss_pkg::SLOT_W'(1);
    end
  end

  // Entry count
  assign count_nxt = cmd.wr_new ? count_r + sss_pkg::COUNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Output register: load on commit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= cmd.res_status;
      out_slot_r   <= (cmd.res_status == sss_pkg::STAT_FULL) ? '0 : slot_r;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = out_count_r;

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sss_pkg::COUNT_W'(sss_pkg::TABLE_ENTRIES))
    else $error("entry count exceeds table size");
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.wr_new |=> $stable(count_r))
    else $error("entry count moved without an insertion");

endmodule
